// ===== design/rt_pkg.sv =====
// ----------------------------------------------------------------------------
// rt_pkg
// Shared types and constants for the rank transform block: payload widths,
// the element write request, the queued set command and the back-end states.
// ----------------------------------------------------------------------------
package rt_pkg;

	// Width of one stored element.
	localparam int DATA_W = 32;
	// Width of the emitted rank.
	localparam int RANK_W = 6;
	// Element count width at the largest supported capacity (64 entries).
	localparam int CNT_W = 7;
	// Element index width at the largest supported capacity.
	localparam int IDX_W = 6;

	// One element written into the store by the front end.
	typedef struct packed {
		logic              en;
		logic              bank;
		logic [IDX_W-1:0]  idx;
		logic [DATA_W-1:0] data;
	} rt_wr_t;

	// A closed set waiting to be ranked.
	typedef struct packed {
		logic             bank;
		logic [CNT_W-1:0] count;
		logic             ovf;
	} rt_cmd_t;

	// The back end hands a bank back to the front end.
	typedef struct packed {
		logic vld;
		logic bank;
	} rt_release_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_KEY,
		BK_SCAN,
		BK_DRAIN,
		BK_EMIT
	} rt_back_state_t;

endpackage

// ===== design/rt_front.sv =====
// ----------------------------------------------------------------------------
// rt_front
// Accepts input transactions, writes each element into the active bank,
// tracks count and overflow, and on the closing element queues the set.
// ----------------------------------------------------------------------------
module rt_front #(
	parameter int MAX_ELEMENTS = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [rt_pkg::DATA_W-1:0] value,
	input  logic                      final_req,
	input  logic                      q_full,
	output logic                      q_push,
	output rt_pkg::rt_cmd_t           q_cmd,
	output rt_pkg::rt_wr_t            wr,
	input  rt_pkg::rt_release_t       release_bank
);
	import rt_pkg::*;

	localparam int AW = $clog2(MAX_ELEMENTS);
	localparam int CW = $clog2(MAX_ELEMENTS + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ELEMENTS);

	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic          bank_q;
	logic [1:0]    busy_q;

	logic          accept;
	logic          has_room;
	logic [CW-1:0] n_total;

	assign in_ready = !busy_q[bank_q] && !q_full;
	assign accept   = in_valid && in_ready;
	assign has_room = (count_q < MAX_CNT);
	assign n_total  = has_room ? (count_q + CW'(1)) : count_q;

	assign wr.en   = accept && has_room;
	assign wr.bank = bank_q;
	assign wr.idx  = IDX_W'(count_q[AW-1:0]);
	assign wr.data = value;

	assign q_push      = accept && final_req;
	assign q_cmd.bank  = bank_q;
	assign q_cmd.count = CNT_W'(n_total);
	assign q_cmd.ovf   = ovf_q || !has_room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			bank_q  <= 1'b0;
		end else if (accept) begin
			if (final_req) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
				bank_q  <= !bank_q;
			end else if (has_room) begin
				count_q <= count_q + CW'(1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	// A bank stays busy from the moment its set is queued until the back end
	// has loaded the last rank of that set into its output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
		end else begin
			for (int b = 0; b < 2; b++) begin
				if (q_push && (bank_q == b[0])) begin
					busy_q[b] <= 1'b1;
				end else if (release_bank.vld && (release_bank.bank == b[0])) begin
					busy_q[b] <= 1'b0;
				end
			end
		end
	end

`ifndef ASSERT_OFF
	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> !busy_q[wr.bank])
		else $error("element written into a bank that is still being ranked");
`endif

endmodule

// ===== design/rt_cmdq.sv =====
// ----------------------------------------------------------------------------
// rt_cmdq
// Two-entry queue of closed sets between the front end and the back end.
// ----------------------------------------------------------------------------
module rt_cmdq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  rt_pkg::rt_cmd_t cmd_in,
	output logic            full,
	input  logic            pop,
	output rt_pkg::rt_cmd_t head,
	output logic            vld
);
	import rt_pkg::*;

	rt_cmd_t    entries_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign vld  = (cnt_q != 2'd0);
	assign head = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("set command pushed into a full queue");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> vld)
		else $error("set command popped from an empty queue");
`endif

endmodule

// ===== design/rt_back.sv =====
// ----------------------------------------------------------------------------
// rt_back
// Holds the two-bank element store and ranks a queued set: for each element
// it reads the key, scans the set counting values not above it, then loads
// the result into the output register.
// ----------------------------------------------------------------------------
module rt_back #(
	parameter int MAX_ELEMENTS = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rt_pkg::rt_wr_t            wr,
	input  logic                      q_vld,
	input  rt_pkg::rt_cmd_t           q_head,
	output logic                      q_pop,
	output rt_pkg::rt_release_t       release_bank,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [rt_pkg::RANK_W-1:0] rank,
	output logic                      run_end,
	output logic                      overflowed
);
	import rt_pkg::*;

	localparam int AW    = $clog2(MAX_ELEMENTS);
	localparam int CW    = $clog2(MAX_ELEMENTS + 1);
	localparam int MEM_D = 2 * (1 << AW);

	logic [DATA_W-1:0] mem_q [MEM_D];
	logic [DATA_W-1:0] rd_data_q;

	rt_back_state_t state_q, state_d;

	logic          bank_q;
	logic [CW-1:0] n_q;
	logic          ovf_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] j_q;
	logic [CW-1:0] cnt_q;
	logic [DATA_W-1:0] key_q;
	logic          key_vld_s1;
	logic          cmp_vld_s1;

	logic              out_vld_q;
	logic [RANK_W-1:0] rank_q;
	logic              run_end_q;
	logic              ovf_out_q;

	logic          rd_en;
	logic [CW-1:0] rd_idx;
	logic [AW:0]   rd_addr;
	logic          load_out;
	logic          out_free;
	logic          last_elem;
	logic          scan_done;
	logic          le;

	assign out_free  = !out_vld_q || out_ready;
	assign last_elem = (i_q == (n_q - CW'(1)));
	assign scan_done = (j_q == (n_q - CW'(1)));
	assign le        = ($signed(rd_data_q) <= $signed(key_q));
	assign rd_addr   = {bank_q, rd_idx[AW-1:0]};

	// Store: one write port for the front end, one registered read port.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[{wr.bank, wr.idx[AW-1:0]}] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE:  if (q_vld) state_d = BK_KEY;
			BK_KEY:   state_d = BK_SCAN;
			BK_SCAN:  if (scan_done) state_d = BK_DRAIN;
			BK_DRAIN: state_d = BK_EMIT;
			BK_EMIT: begin
				if (out_free) begin
					state_d = last_elem ? BK_IDLE : BK_KEY;
				end
			end
			default:  state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		rd_en             = 1'b0;
		rd_idx            = j_q;
		q_pop             = 1'b0;
		load_out          = 1'b0;
		release_bank.vld  = 1'b0;
		release_bank.bank = bank_q;
		case (state_q)
			BK_IDLE: q_pop = q_vld;
			BK_KEY: begin
				rd_en  = 1'b1;
				rd_idx = i_q;
			end
			BK_SCAN: rd_en = 1'b1;
			BK_EMIT: begin
				load_out         = out_free;
				release_bank.vld = out_free && last_elem;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_IDLE;
			key_vld_s1 <= 1'b0;
			cmp_vld_s1 <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			key_vld_s1 <= (state_q == BK_KEY);
			cmp_vld_s1 <= (state_q == BK_SCAN);
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			bank_q <= q_head.bank;
			n_q    <= CW'(q_head.count);
			ovf_q  <= q_head.ovf;
			i_q    <= '0;
		end
		if (state_q == BK_KEY) begin
			j_q   <= '0;
			cnt_q <= '0;
		end
		if (state_q == BK_SCAN) begin
			j_q <= j_q + CW'(1);
		end
		if (key_vld_s1) begin
			key_q <= rd_data_q;
		end
		if (cmp_vld_s1 && le) begin
			cnt_q <= cnt_q + CW'(1);
		end
		if (load_out) begin
			rank_q    <= RANK_W'(cnt_q - CW'(1));
			run_end_q <= last_elem;
			ovf_out_q <= ovf_q;
			i_q       <= i_q + CW'(1);
		end
	end

	assign out_valid  = out_vld_q;
	assign rank       = rank_q;
	assign run_end    = run_end_q;
	assign overflowed = ovf_out_q;

`ifndef ASSERT_OFF
	a_out_not_clobbered: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!out_vld_q || out_ready))
		else $error("result register overwritten before it was taken");
	a_key_before_compare: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_vld_s1 |-> $past(state_q == BK_SCAN))
		else $error("compare data arrived outside a scan");
	a_release_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		release_bank.vld |=> (out_vld_q && run_end_q))
		else $error("bank released without the run end result");
`endif

endmodule

// ===== design/rank_transform_core.sv =====
// ----------------------------------------------------------------------------
// rank_transform_core
// Ranks each value of a set of signed 32-bit elements by its sorted position.
// ----------------------------------------------------------------------------
// Each input transaction carries one element; the transaction with final_req
// high closes the set. Once a set is closed the block emits one output
// transaction per stored element, in arrival order, whose rank is the number
// of stored elements less than or equal to it, minus one, so equal values
// share their highest sorted position. run_end marks the rank of the last
// stored element, and overflowed is high on every result of a set in which
// elements beyond MAX_ELEMENTS were dropped (only the first MAX_ELEMENTS are
// ranked). Ranking is limited by the single read port of the element store,
// which is scanned once per result. The store has two banks, so the next set
// loads while the previous one is ranked; a third set waits until the older
// bank is released. No clearing pass runs after reset.
// ----------------------------------------------------------------------------
module rank_transform_core #(
	parameter int MAX_ELEMENTS = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [rt_pkg::DATA_W-1:0] value,
	input  logic                      final_req,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [rt_pkg::RANK_W-1:0] rank,
	output logic                      run_end,
	output logic                      overflowed
);
	import rt_pkg::*;

	// Front end to queue and store.
	rt_wr_t      wr;
	rt_cmd_t     push_cmd;
	logic        push;
	logic        q_full;

	// Queue to back end.
	rt_cmd_t     head_cmd;
	logic        q_vld;
	logic        pop;

	// Back end hands a finished bank back to the front end.
	rt_release_t release_bank;

	rt_front #(
		.MAX_ELEMENTS(MAX_ELEMENTS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.value       (value),
		.final_req   (final_req),
		.q_full      (q_full),
		.q_push      (push),
		.q_cmd       (push_cmd),
		.wr          (wr),
		.release_bank(release_bank)
	);

	rt_cmdq u_cmdq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.cmd_in(push_cmd),
		.full  (q_full),
		.pop   (pop),
		.head  (head_cmd),
		.vld   (q_vld)
	);

	rt_back #(
		.MAX_ELEMENTS(MAX_ELEMENTS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr          (wr),
		.q_vld       (q_vld),
		.q_head      (head_cmd),
		.q_pop       (pop),
		.release_bank(release_bank),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.rank        (rank),
		.run_end     (run_end),
		.overflowed  (overflowed)
	);

endmodule

// ===== tb/rank_transform_core_tb.sv =====
// ----------------------------------------------------------------------------
// rank_transform_core_tb
// Self-checking testbench for the rank transform block.
// ----------------------------------------------------------------------------
// Sets of signed 32-bit elements are streamed in, one per input transaction.
// The last element of each set carries final_req. A predictor in the bench
// keeps its own copy of the open set. When a closing transaction is
// accepted, it works out the rank, run_end and overflowed fields of every
// stored element and queues them in arrival order. A monitor compares each
// output transaction, field by field, with the oldest queued result.
//
// A short directed part comes first: the numeric extremes, ties, a
// one-element set and a descending set. Random sets follow. Most of them
// are small, and a few fill the store exactly or overflow it. Both sides
// idle at random, except during one quiet stretch. The sender also pauses
// now and then until the block has drained completely.
// ----------------------------------------------------------------------------
module rank_transform_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rt_pkg::*;

	localparam int MAX_ELEMENTS = 64;
	localparam int ITEM_TARGET = 480;
	localparam int IDLE_PCT = 30;

	typedef enum logic [1:0] {
		VAL_WIDE,
		VAL_TIED,
		VAL_EDGE
	} value_mode_t;

	// One element waiting to be driven. When drain_first is set, the driver
	// holds it back until every outstanding rank has been received.
	typedef struct {
		logic [DATA_W-1:0] value;
		logic              last;
		bit                drain_first;
	} elem_item_t;

	// One expected output transaction.
	typedef struct packed {
		logic [RANK_W-1:0] rank;
		logic              run_end;
		logic              overflowed;
	} rank_result_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [DATA_W-1:0] value;
	logic              final_req;
	logic              out_valid;
	logic              out_ready;
	logic [RANK_W-1:0] rank;
	logic              run_end;
	logic              overflowed;

	elem_item_t        elem_q[$];
	rank_result_t      rank_q[$];

	// Predictor state: the elements of the open set, and whether any were
	// dropped because the store was full.
	logic [DATA_W-1:0] set_elems[$];
	bit                set_dropped;

	int                errors;
	int                items_queued;
	int                items_taken;
	bit                in_taken;
	bit                quiet;

	rank_transform_core #(
		.MAX_ELEMENTS(MAX_ELEMENTS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.value(value),
		.final_req(final_req),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.rank(rank),
		.run_end(run_end),
		.overflowed(overflowed)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Print one mismatch line and count it.
	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		$display("[%0t] mismatch %0d: %s got %0d, expected %0d", $realtime, errors, what,
			got, want);
	endtask

	// Add one accepted element to the open set. On a closing element, rank
	// every stored element against all the others. Elements that arrive
	// while the store is full, the closing one included, are dropped and
	// only mark the set as overflowed.
	task automatic absorb_element(input logic [DATA_W-1:0] v, input logic last);
		int           n;
		int           cnt;
		rank_result_t res;
		if (set_elems.size() < MAX_ELEMENTS) begin
			set_elems.push_back(v);
		end else begin
			set_dropped = 1'b1;
		end
		if (!last) return;
		n = set_elems.size();
		for (int i = 0; i < n; i++) begin
			cnt = 0;
			for (int j = 0; j < n; j++) begin
				if ($signed(set_elems[j]) <= $signed(set_elems[i])) cnt++;
			end
			res.rank = RANK_W'(cnt - 1);
			res.run_end = (i == n - 1);
			res.overflowed = set_dropped;
			rank_q.push_back(res);
		end
		set_elems.delete();
		set_dropped = 1'b0;
	endtask

	task automatic add_item(input logic [DATA_W-1:0] v, input logic last,
			input bit drain_first = 1'b0);
		elem_item_t it;
		it.value = v;
		it.last = last;
		it.drain_first = drain_first;
		elem_q.push_back(it);
		items_queued++;
	endtask

	function automatic logic [DATA_W-1:0] pick_value(input value_mode_t mode);
		logic [DATA_W-1:0] v;
		v = $urandom;
		case (mode)
			VAL_TIED: begin
				v = DATA_W'($signed($urandom_range(6)) - 3);
			end
			VAL_EDGE: begin
				case ($urandom_range(4))
					0: v = 32'h8000_0000;
					1: v = 32'h7FFF_FFFF;
					2: v = 32'h0000_0000;
					3: v = 32'hFFFF_FFFF;
					default: v = $urandom;
				endcase
			end
			default: begin
			end
		endcase
		return v;
	endfunction

	// Queue one set of n elements, the last one closing the set.
	task automatic add_set(input int n, input bit drain_first = 1'b0);
		value_mode_t mode;
		mode = value_mode_t'($urandom_range(2));
		for (int i = 0; i < n; i++) begin
			add_item(pick_value(mode), i == n - 1, drain_first && i == 0);
		end
	endtask

	// Sender: new payloads change only on the falling edge. Valid stays high
	// with a stable payload until the transaction has been taken. During the
	// quiet stretch there are no random gaps.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			in_taken = 1'b0;
			if (elem_q.size() > 0 && !(elem_q[0].drain_first && rank_q.size() != 0) &&
					(quiet || $urandom_range(99) >= IDLE_PCT)) begin
				in_valid <= 1'b1;
				value <= elem_q[0].value;
				final_req <= elem_q[0].last;
				void'(elem_q.pop_front());
			end else begin
				in_valid <= 1'b0;
			end
		end
		if (arst_n) begin
			out_ready <= quiet || $urandom_range(99) >= IDLE_PCT;
		end
	end

	// Monitor: both channels are sampled on the rising edge. An accepted
	// input transaction goes to the predictor. An accepted output
	// transaction is checked against the oldest expected rank.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				in_taken = 1'b1;
				items_taken++;
				quiet = (items_taken >= 150 && items_taken < 260);
				absorb_element(value, final_req);
			end
			if (out_valid && out_ready) begin
				if (rank_q.size() == 0) begin
					report_mismatch("unexpected result, rank", int'(rank), -1);
				end else begin
					if (rank !== rank_q[0].rank) begin
						report_mismatch("rank", int'(rank), int'(rank_q[0].rank));
					end
					if (run_end !== rank_q[0].run_end) begin
						report_mismatch("run_end", int'(run_end), int'(rank_q[0].run_end));
					end
					if (overflowed !== rank_q[0].overflowed) begin
						report_mismatch("overflowed", int'(overflowed),
							int'(rank_q[0].overflowed));
					end
					void'(rank_q.pop_front());
				end
			end
		end
	end

	// Run limit: far more than the slowest correct run needs.
	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		int r;
		bit full_done;
		bit ovf_done;
		bit ovf_long_done;
		arst_n = 1'b0;
		in_valid = 1'b0;
		value = '0;
		final_req = 1'b0;
		out_ready = 1'b0;
		errors = 0;
		items_queued = 0;
		items_taken = 0;
		in_taken = 1'b0;
		quiet = 1'b0;
		set_dropped = 1'b0;
		full_done = 1'b0;
		ovf_done = 1'b0;
		ovf_long_done = 1'b0;

		// Directed part. A one-element set at the most negative value.
		add_item(32'h8000_0000, 1'b1);
		// Both extremes, zero and the values next to it.
		add_item(32'h7FFF_FFFF, 1'b0);
		add_item(32'h8000_0000, 1'b0);
		add_item(32'h0000_0000, 1'b0);
		add_item(32'hFFFF_FFFF, 1'b0);
		add_item(32'h0000_0001, 1'b1);
		// Ties share the highest sorted position.
		add_item(32'd5, 1'b0);
		add_item(32'd5, 1'b0);
		add_item(32'd5, 1'b0);
		add_item(32'hFFFF_FFFD, 1'b0);
		add_item(32'd5, 1'b1);
		// All equal at the top of the range.
		add_item(32'h7FFF_FFFF, 1'b0);
		add_item(32'h7FFF_FFFF, 1'b0);
		add_item(32'h7FFF_FFFF, 1'b1);
		// Alternating bit patterns toggle every bit of value.
		add_item(32'h5555_5555, 1'b0);
		add_item(32'hAAAA_AAAA, 1'b1);
		// Descending order.
		add_item(32'd3, 1'b0);
		add_item(32'd2, 1'b0);
		add_item(32'd1, 1'b0);
		add_item(32'd0, 1'b1);

		// Random part. Most sets are small, because ranking time grows with
		// the square of the set size. A few sets fill the store exactly or
		// overflow it, in which case the closing element itself is dropped.
		add_set($urandom_range(8, 1), 1'b1);
		while (items_queued < ITEM_TARGET) begin
			if (!full_done && items_queued >= 100) begin
				add_set(MAX_ELEMENTS, 1'b1);
				full_done = 1'b1;
			end else if (!ovf_done && items_queued >= 300) begin
				add_set(MAX_ELEMENTS + 1);
				ovf_done = 1'b1;
			end else if (!ovf_long_done && items_queued >= 400) begin
				add_set(MAX_ELEMENTS + $urandom_range(8, 2), 1'b1);
				ovf_long_done = 1'b1;
			end else begin
				r = $urandom_range(99);
				if (r < 70) begin
					add_set($urandom_range(8, 1));
				end else if (r < 92) begin
					add_set($urandom_range(24, 9));
				end else begin
					add_set($urandom_range(40, 25));
				end
			end
		end

		// Reset is released on a falling edge.
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for all stimulus to be taken and all ranks to come back, then
		// allow some extra cycles in which no stray result may appear.
		while (elem_q.size() != 0 || in_valid) @(posedge clk);
		while (rank_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);

		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
